>>> src/gzhp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzhp_pkg: shared types and constants of the gzip member header parser
// Field widths, magic and flag constants, error, phase and section codes.
// ----------------------------------------------------------------------------
package gzhp_pkg;

   // Field widths of the request and response items.
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SIZE_W   = 31;
   localparam int unsigned FLAGS_W  = 5;
   localparam int unsigned XLEN_W   = 16;

   // Packed bus widths, rounded up to whole bytes.
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 40;

   // Header constants.
   localparam logic [7:0] MAGIC_ID1      = 8'h1F;
   localparam logic [7:0] MAGIC_ID2      = 8'h8B;
   localparam logic [7:0] METHOD_DEFLATE = 8'h08;
   localparam logic [7:0] FLG_RESERVED   = 8'hE0;

   // Bit positions inside the FLG byte.
   localparam int unsigned FLG_FHCRC    = 1;
   localparam int unsigned FLG_FEXTRA   = 2;
   localparam int unsigned FLG_FNAME    = 3;
   localparam int unsigned FLG_FCOMMENT = 4;

   // Member size limits.
   localparam logic [SIZE_W-1:0] MIN_MEMBER   = 31'd18;
   localparam logic [SIZE_W-1:0] TRAILER_LEN  = 31'd8;
   // Byte index of OS, the last byte of the fixed header part.
   localparam logic [SIZE_W-1:0] FIXED_LAST   = 31'd9;

   // Error codes reported with a response.
   typedef enum logic [3:0] {
      ERR_NONE    = 4'd0,
      ERR_SHORT   = 4'd1,
      ERR_MAGIC   = 4'd2,
      ERR_METHOD  = 4'd3,
      ERR_FLAGS   = 4'd4,
      ERR_EXTRA   = 4'd5,
      ERR_NAME    = 4'd6,
      ERR_COMMENT = 4'd7,
      ERR_HCRC    = 4'd8,
      ERR_NODATA  = 4'd9
   } err_type;

   // Response phase codes.
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_END    = 2'd1,
      PH_ERROR  = 2'd2,
      PH_PAST   = 2'd3
   } phase_type;

   // Optional header sections, in the order they appear.
   typedef enum logic [2:0] {
      SEC_EXTRA   = 3'd0,
      SEC_NAME    = 3'd1,
      SEC_COMMENT = 3'd2,
      SEC_HCRC    = 3'd3,
      SEC_END     = 3'd4
   } sec_type;

endpackage : gzhp_pkg
`default_nettype wire

>>> src/gzip_member_header_parser_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gzip_member_header_parser_top: gzip member header parser
// Walks the bytes of a gzip member one per request, checks the fixed header,
// skips the optional fields and reports the deflate start or an error code.
// ----------------------------------------------------------------------------
// The response to an accepted request is registered into rsp_tdata the next
// cycle. Throughput: one request per cycle while rsp_tready is high; the byte
// is parsed by a single state and counter update in front of the response
// register, which also acts as the pipeline stage between the two channels.
// Reset: synchronous; the parser waits for a first byte, with every counter
// and the latched error cleared and no response pending.
module gzip_member_header_parser_top
   import gzhp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // req_tdata: [7:0] byte_value, [38:8] member_size, [39] zero pad.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: [0] first_byte.
   input  wire logic                  req_tuser,
   // Response channel.
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // rsp_tdata: [3:0] error_code, [34:4] data_offset, [39:35] header_flags.
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: [1:0] phase.
   output      logic [1:0]            rsp_tuser
);

   typedef enum logic [3:0] {
      ST_DONE,
      ST_FIXED,
      ST_XLO,
      ST_XHI,
      ST_XSKIP,
      ST_NAME,
      ST_COMMENT,
      ST_HCRC1,
      ST_HCRC2
   } state_type;

   // Outcome of entering the next present header section.
   typedef struct packed {
      state_type st;
      logic      fail;
      logic      finish;
      err_type   code;
   } enter_type;

   // Parser state.
   state_type          state_ff,  state_in;
   logic [SIZE_W-1:0]  pos_ff,    pos_in;
   logic [SIZE_W-1:0]  limit_ff,  limit_in;
   logic [FLAGS_W-1:0] flags_ff,  flags_in;
   logic [XLEN_W-1:0]  xrem_ff,   xrem_in;
   logic [BYTE_W-1:0]  xlow_ff,   xlow_in;
   err_type            err_ff,    err_in;

   // Response register.
   logic               rsp_valid_ff;
   phase_type          phase_ff,  phase_in;
   err_type            code_ff,   code_in;
   logic [SIZE_W-1:0]  offset_ff, offset_in;

   logic               accept;
   logic [BYTE_W-1:0]  in_byte;
   logic [SIZE_W-1:0]  in_size;
   logic               in_first;

   assign in_byte  = req_tdata[BYTE_W-1:0];
   assign in_size  = req_tdata[BYTE_W+SIZE_W-1:BYTE_W];
   assign in_first = req_tuser;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = phase_ff;
   assign rsp_tdata  = {flags_ff, offset_ff, code_ff};

   // Pick the first present section at or after sec, with the next byte at off.
   function automatic enter_type enter_section(
      input sec_type           sec,
      input logic [31:0]       off,
      input logic [FLAGS_W-1:0] flg,
      input logic [SIZE_W-1:0] lim
   );
      enter_type   r;
      logic [32:0] off_w;
      logic [32:0] off2_w;
      logic [32:0] lim_w;
      off_w  = {1'b0, off};
      off2_w = off_w + 33'd2;
      lim_w  = {2'b00, lim};
      r      = '{st: ST_DONE, fail: 1'b0, finish: 1'b0, code: ERR_NONE};
      if (sec <= SEC_EXTRA && flg[FLG_FEXTRA]) begin
         if (off2_w > lim_w) begin
            r.fail = 1'b1;
            r.code = ERR_EXTRA;
         end else begin
            r.st = ST_XLO;
         end
      end else if (sec <= SEC_NAME && flg[FLG_FNAME]) begin
         if (off_w >= lim_w) begin
            r.fail = 1'b1;
            r.code = ERR_NAME;
         end else begin
            r.st = ST_NAME;
         end
      end else if (sec <= SEC_COMMENT && flg[FLG_FCOMMENT]) begin
         if (off_w >= lim_w) begin
            r.fail = 1'b1;
            r.code = ERR_COMMENT;
         end else begin
            r.st = ST_COMMENT;
         end
      end else if (sec <= SEC_HCRC && flg[FLG_FHCRC]) begin
         if (off2_w > lim_w) begin
            r.fail = 1'b1;
            r.code = ERR_HCRC;
         end else begin
            r.st = ST_HCRC1;
         end
      end else if (off_w >= lim_w) begin
         r.fail = 1'b1;
         r.code = ERR_NODATA;
      end else begin
         r.finish = 1'b1;
      end
      return r;
   endfunction

   // Next state and response for the byte in the request.
   always_comb begin
      logic        do_fail;
      err_type     fail_code;
      logic        do_enter;
      sec_type     enter_sec;
      logic [31:0] enter_off;
      logic [31:0] next_off;
      logic [32:0] xend;
      logic [15:0] xlen;
      enter_type   er;

      state_in  = state_ff;
      pos_in    = pos_ff;
      limit_in  = limit_ff;
      flags_in  = flags_ff;
      xrem_in   = xrem_ff;
      xlow_in   = xlow_ff;
      err_in    = err_ff;
      phase_in  = PH_HEADER;
      code_in   = ERR_NONE;
      offset_in = '0;

      do_fail   = 1'b0;
      fail_code = ERR_NONE;
      do_enter  = 1'b0;
      enter_sec = SEC_EXTRA;
      enter_off = '0;

      // Offset of the byte after this one; it may reach 2^31.
      next_off  = {1'b0, pos_ff + 31'd1} + 32'd1;
      xlen      = {in_byte, xlow_ff};
      xend      = {1'b0, next_off} + {17'd0, xlen};
      er        = '{st: ST_DONE, fail: 1'b0, finish: 1'b0, code: ERR_NONE};

      if (in_first) begin
         // Start of a new member: drop whatever was in progress.
         pos_in   = '0;
         flags_in = '0;
         xrem_in  = '0;
         xlow_in  = '0;
         err_in   = ERR_NONE;
         limit_in = '0;
         if (in_size < MIN_MEMBER) begin
            do_fail   = 1'b1;
            fail_code = ERR_SHORT;
         end else begin
            limit_in = in_size - TRAILER_LEN;
            if (in_byte != MAGIC_ID1) begin
               do_fail   = 1'b1;
               fail_code = ERR_MAGIC;
            end else begin
               state_in = ST_FIXED;
            end
         end
      end else if (state_ff == ST_DONE) begin
         // Bytes past the header or after an error.
         phase_in = PH_PAST;
         code_in  = err_ff;
      end else begin
         pos_in = pos_ff + 31'd1;
         unique case (state_ff)
            ST_FIXED: begin
               if (pos_in == 31'd1) begin
                  if (in_byte != MAGIC_ID2) begin
                     do_fail   = 1'b1;
                     fail_code = ERR_MAGIC;
                  end
               end else if (pos_in == 31'd2) begin
                  if (in_byte != METHOD_DEFLATE) begin
                     do_fail   = 1'b1;
                     fail_code = ERR_METHOD;
                  end
               end else if (pos_in == 31'd3) begin
                  flags_in = in_byte[FLAGS_W-1:0];
                  if ((in_byte & FLG_RESERVED) != 8'd0) begin
                     do_fail   = 1'b1;
                     fail_code = ERR_FLAGS;
                  end
               end else if (pos_in >= FIXED_LAST) begin
                  do_enter  = 1'b1;
                  enter_sec = SEC_EXTRA;
                  enter_off = 32'd10;
               end
            end
            ST_XLO: begin
               xlow_in  = in_byte;
               state_in = ST_XHI;
            end
            ST_XHI: begin
               xrem_in = xlen;
               if (xend > {2'b00, limit_ff}) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_EXTRA;
               end else if (xlen == 16'd0) begin
                  do_enter  = 1'b1;
                  enter_sec = SEC_NAME;
                  enter_off = next_off;
               end else begin
                  state_in = ST_XSKIP;
               end
            end
            ST_XSKIP: begin
               xrem_in = xrem_ff - 16'd1;
               if (xrem_in == 16'd0) begin
                  do_enter  = 1'b1;
                  enter_sec = SEC_NAME;
                  enter_off = next_off;
               end
            end
            ST_NAME, ST_COMMENT: begin
               if (in_byte == 8'd0) begin
                  do_enter  = 1'b1;
                  enter_sec = (state_ff == ST_NAME) ? SEC_COMMENT : SEC_HCRC;
                  enter_off = next_off;
               end else if ({1'b0, next_off} >= {2'b00, limit_ff}) begin
                  do_fail   = 1'b1;
                  fail_code = (state_ff == ST_NAME) ? ERR_NAME : ERR_COMMENT;
               end
            end
            ST_HCRC1: begin
               state_in = ST_HCRC2;
            end
            ST_HCRC2: begin
               do_enter  = 1'b1;
               enter_sec = SEC_END;
               enter_off = next_off;
            end
            default: begin
               state_in = ST_DONE;
               phase_in = PH_PAST;
               code_in  = err_ff;
            end
         endcase
      end

      // Move on to the next section, which may end the header.
      if (do_enter) begin
         er = enter_section(enter_sec, enter_off, flags_ff, limit_ff);
         if (er.fail) begin
            do_fail   = 1'b1;
            fail_code = er.code;
         end else if (er.finish) begin
            state_in  = ST_DONE;
            err_in    = ERR_NONE;
            phase_in  = PH_END;
            offset_in = enter_off[SIZE_W-1:0];
         end else begin
            state_in = er.st;
         end
      end

      // An error ends the parse and is latched for the bytes that follow.
      if (do_fail) begin
         state_in = ST_DONE;
         err_in   = fail_code;
         phase_in = PH_ERROR;
         code_in  = fail_code;
      end
   end

   // Parser state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DONE;
         pos_ff       <= '0;
         limit_ff     <= '0;
         flags_ff     <= '0;
         xrem_ff      <= '0;
         xlow_ff      <= '0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_HEADER;
         code_ff      <= ERR_NONE;
         offset_ff    <= '0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            pos_ff       <= pos_in;
            limit_ff     <= limit_in;
            flags_ff     <= flags_in;
            xrem_ff      <= xrem_in;
            xlow_ff      <= xlow_in;
            err_ff       <= err_in;
            rsp_valid_ff <= 1'b1;
            phase_ff     <= phase_in;
            code_ff      <= code_in;
            offset_ff    <= offset_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTH
   // A short member is rejected in the response to its first byte.
   a_short_member: assert property (@(posedge clock) disable iff (reset)
      (accept && in_first && in_size < MIN_MEMBER) |=>
         (rsp_valid_ff && phase_ff == PH_ERROR && code_ff == ERR_SHORT))
      else $error("short member not rejected");

   // A header end carries no error code.
   a_end_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && phase_ff == PH_END) |-> (code_ff == ERR_NONE))
      else $error("header end reported with an error code");

   // Inside the header neither an error nor an offset is reported.
   a_header_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && phase_ff == PH_HEADER) |->
         (code_ff == ERR_NONE && offset_ff == '0))
      else $error("header phase carries error or offset");

   // An active parse always has room for the fixed header before the trailer.
   a_limit_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DONE) |-> (limit_ff >= MIN_MEMBER - TRAILER_LEN))
      else $error("parse active with a trailer limit below the minimum");
`endif

endmodule : gzip_member_header_parser_top
`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the gzip member header parser
// Feeds one member byte per request: first a short table of edge cases,
// then random members (mostly well formed, some truncated or corrupted,
// with stray bytes in between). Typed table rows are checked against their own
// answer, all else against a behavioral header walker run per accepted request.
// ----------------------------------------------------------------------------
module testbench
   import gzhp_pkg::*;
();

   localparam int unsigned RANDOM_BYTES = 1500;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PRINT_CAP    = 40;
   localparam logic [SIZE_W-1:0] SIZE_TOP = '1;

   // Walker states: idle, then the steps through each section of the header.
   typedef enum logic [3:0] {
      WS_IDLE, WS_FIXED, WS_XLO, WS_XHI, WS_XSKIP,
      WS_NAME, WS_COMMENT, WS_HCRC1, WS_HCRC2
   } walk_state_type;

   // One response as the parser should report it.
   typedef struct packed {
      phase_type          phase;
      err_type            err;
      logic [SIZE_W-1:0]  offset;
      logic [FLAGS_W-1:0] flags;
   } hdr_result_type;

   // One row of the edge-case table; typed rows carry their own answer.
   typedef struct packed {
      logic [BYTE_W-1:0]  value;
      logic [SIZE_W-1:0]  size;
      logic               first;
      logic               typed;
      hdr_result_type     answer;
   } edge_row_type;

   localparam int unsigned EDGE_N = 25;
   localparam edge_row_type EDGE_ROWS [0:EDGE_N-1] = '{
      // Stray byte straight after reset.
      '{8'h00, 31'd0,  1'b0, 1'b1, '{PH_PAST,   ERR_NONE,   31'd0, 5'h00}},
      // Member sizes below the minimum, then a stray byte keeps the code.
      '{8'hFF, 31'd0,  1'b1, 1'b1, '{PH_ERROR,  ERR_SHORT,  31'd0, 5'h00}},
      '{8'h1F, 31'd17, 1'b1, 1'b1, '{PH_ERROR,  ERR_SHORT,  31'd0, 5'h00}},
      '{8'h00, 31'd0,  1'b0, 1'b1, '{PH_PAST,   ERR_SHORT,  31'd0, 5'h00}},
      // Largest size with a bad first magic byte, then a good one.
      '{8'h1E, SIZE_TOP, 1'b1, 1'b1, '{PH_ERROR, ERR_MAGIC, 31'd0, 5'h00}},
      '{8'h1F, SIZE_TOP, 1'b1, 1'b1, '{PH_HEADER, ERR_NONE, 31'd0, 5'h00}},
      // Restart in the middle of a member, then a bad method byte.
      '{8'h1F, 31'd18, 1'b1, 1'b1, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}},
      '{8'h8B, 31'd0,  1'b0, 1'b1, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}},
      '{8'h09, 31'd0,  1'b0, 1'b1, '{PH_ERROR,  ERR_METHOD, 31'd0, 5'h00}},
      // Reserved flag bits set; the low flag bits still show.
      '{8'h1F, 31'd18, 1'b1, 1'b1, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}},
      '{8'h8B, SIZE_TOP, 1'b0, 1'b1, '{PH_HEADER, ERR_NONE, 31'd0, 5'h00}},
      '{8'h08, 31'd0,  1'b0, 1'b1, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}},
      '{8'hFF, 31'd0,  1'b0, 1'b1, '{PH_ERROR,  ERR_FLAGS,  31'd0, 5'h1F}},
      '{8'h00, 31'd0,  1'b0, 1'b1, '{PH_PAST,   ERR_FLAGS,  31'd0, 5'h1F}},
      // Every optional field in the smallest member: no room for the extra
      // length, which is decided at the last fixed byte.
      '{8'h1F, 31'd18, 1'b1, 1'b1, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}},
      '{8'h8B, 31'd0,  1'b0, 1'b1, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}},
      '{8'h08, 31'd0,  1'b0, 1'b1, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}},
      '{8'h1E, 31'd0,  1'b0, 1'b1, '{PH_HEADER, ERR_NONE,   31'd0, 5'h1E}},
      '{8'h00, 31'd0,  1'b0, 1'b0, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}},
      '{8'hFF, 31'd0,  1'b0, 1'b0, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}},
      '{8'h55, 31'd0,  1'b0, 1'b0, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}},
      '{8'hAA, 31'd0,  1'b0, 1'b0, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}},
      '{8'h80, 31'd0,  1'b0, 1'b0, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}},
      '{8'h03, 31'd0,  1'b0, 1'b1, '{PH_ERROR,  ERR_EXTRA,  31'd0, 5'h1E}},
      '{8'h00, 31'd0,  1'b0, 1'b0, '{PH_HEADER, ERR_NONE,   31'd0, 5'h00}}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   gzip_member_header_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Walker state, mirroring what the parser must remember.
   walk_state_type     walk_state = WS_IDLE;
   logic [SIZE_W-1:0]  walk_pos = '0;
   logic [SIZE_W-1:0]  walk_limit = '0;
   logic [FLAGS_W-1:0] walk_flags = '0;
   logic [XLEN_W-1:0]  extra_left = '0;
   logic [7:0]         extra_low = '0;
   err_type            held_err = ERR_NONE;
   hdr_result_type     walk_out;

   hdr_result_type pending_results [$];
   int unsigned bytes_accepted = 0;
   int unsigned results_seen = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   bit          gaps_off = 1'b0;
   bit          hold_request = 1'b0;
   bit          hold_taken = 1'b0;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stop the header walk with an error code.
   function automatic void walk_fail(input err_type code);
      held_err = code;
      walk_state = WS_IDLE;
      walk_out.phase = PH_ERROR;
      walk_out.err = code;
   endfunction

   // Move to the first present section at or after sec; the next byte is at
   // offset nxt. Room checks for that section are made here.
   function automatic void walk_enter(input sec_type sec, input logic [31:0] nxt);
      longint unsigned o;
      longint unsigned lim;
      o = nxt;
      lim = walk_limit;
      if (sec <= SEC_EXTRA && walk_flags[FLG_FEXTRA]) begin
         if (o + 2 > lim) walk_fail(ERR_EXTRA);
         else walk_state = WS_XLO;
      end else if (sec <= SEC_NAME && walk_flags[FLG_FNAME]) begin
         if (o >= lim) walk_fail(ERR_NAME);
         else walk_state = WS_NAME;
      end else if (sec <= SEC_COMMENT && walk_flags[FLG_FCOMMENT]) begin
         if (o >= lim) walk_fail(ERR_COMMENT);
         else walk_state = WS_COMMENT;
      end else if (sec <= SEC_HCRC && walk_flags[FLG_FHCRC]) begin
         if (o + 2 > lim) walk_fail(ERR_HCRC);
         else walk_state = WS_HCRC1;
      end else if (o >= lim) begin
         walk_fail(ERR_NODATA);
      end else begin
         held_err = ERR_NONE;
         walk_state = WS_IDLE;
         walk_out.phase = PH_END;
         walk_out.offset = nxt[SIZE_W-1:0];
      end
   endfunction

   // Advance the header walk by one byte and return the response it gives.
   function automatic hdr_result_type walk_byte(input logic [7:0] b,
                                                input logic [SIZE_W-1:0] size,
                                                input logic first);
      logic [SIZE_W-1:0] p;
      logic [31:0]       nxt;
      walk_out = '{PH_HEADER, ERR_NONE, '0, '0};
      if (first) begin
         walk_pos = '0;
         walk_flags = '0;
         extra_left = '0;
         extra_low = '0;
         held_err = ERR_NONE;
         walk_limit = '0;
         if (size < MIN_MEMBER) begin
            walk_fail(ERR_SHORT);
         end else begin
            walk_limit = size - TRAILER_LEN;
            if (b != MAGIC_ID1) walk_fail(ERR_MAGIC);
            else walk_state = WS_FIXED;
         end
      end else if (walk_state == WS_IDLE) begin
         walk_out.phase = PH_PAST;
         walk_out.err = held_err;
      end else begin
         p = walk_pos + 1'b1;
         walk_pos = p;
         nxt = {1'b0, p} + 32'd1;
         case (walk_state)
            WS_FIXED: begin
               if (p == 1) begin
                  if (b != MAGIC_ID2) walk_fail(ERR_MAGIC);
               end else if (p == 2) begin
                  if (b != METHOD_DEFLATE) walk_fail(ERR_METHOD);
               end else if (p == 3) begin
                  walk_flags = b[FLAGS_W-1:0];
                  if ((b & FLG_RESERVED) != 8'h00) walk_fail(ERR_FLAGS);
               end else if (p >= FIXED_LAST) begin
                  walk_enter(SEC_EXTRA, {1'b0, FIXED_LAST} + 32'd1);
               end
            end
            WS_XLO: begin
               extra_low = b;
               walk_state = WS_XHI;
            end
            WS_XHI: begin
               extra_left = {b, extra_low};
               if (64'(nxt) + 64'(extra_left) > 64'(walk_limit)) walk_fail(ERR_EXTRA);
               else if (extra_left == 0) walk_enter(SEC_NAME, nxt);
               else walk_state = WS_XSKIP;
            end
            WS_XSKIP: begin
               extra_left = extra_left - 1'b1;
               if (extra_left == 0) walk_enter(SEC_NAME, nxt);
            end
            WS_NAME: begin
               if (b == 8'h00) walk_enter(SEC_COMMENT, nxt);
               else if (64'(nxt) >= 64'(walk_limit)) walk_fail(ERR_NAME);
            end
            WS_COMMENT: begin
               if (b == 8'h00) walk_enter(SEC_HCRC, nxt);
               else if (64'(nxt) >= 64'(walk_limit)) walk_fail(ERR_COMMENT);
            end
            WS_HCRC1: begin
               walk_state = WS_HCRC2;
            end
            WS_HCRC2: begin
               walk_enter(SEC_END, nxt);
            end
            default: begin
               walk_state = WS_IDLE;
               walk_out.phase = PH_PAST;
               walk_out.err = held_err;
            end
         endcase
      end
      walk_out.flags = walk_flags;
      return walk_out;
   endfunction

   // Offer one byte, wait for the request to be taken, and queue its answer.
   task automatic send_byte(input logic [7:0] value, input logic [SIZE_W-1:0] size,
                            input logic first, input logic typed,
                            input hdr_result_type answer);
      hdr_result_type predicted;
      @(negedge clock);
      while (!gaps_off && $urandom_range(0, 99) < 26) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, size, value};
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      predicted = walk_byte(value, size, first);
      pending_results.push_back(typed ? answer : predicted);
      bytes_accepted++;
   endtask

   // Send a byte whose answer comes from the walker alone.
   task automatic send_walked(input logic [7:0] value, input logic first,
                              input logic [SIZE_W-1:0] size);
      send_byte(value, size, first, 1'b0, '{PH_HEADER, ERR_NONE, '0, '0});
   endtask

   // Build one random member: mostly well formed, with sizes around the
   // point where the header just fits, sometimes corrupted or cut short.
   task automatic send_member();
      logic [7:0]        member_bytes [$];
      logic [4:0]        flg;
      logic [2:0]        reserved;
      logic [SIZE_W-1:0] msize;
      int                kind;
      int                xlen;
      int                slen;
      int                hlen;
      int                count;
      kind = $urandom_range(0, 99);
      flg = 5'($urandom);
      reserved = (kind == 3) ? 3'($urandom_range(1, 7)) : 3'd0;
      member_bytes.push_back(kind == 0 ? 8'($urandom) : MAGIC_ID1);
      member_bytes.push_back(kind == 1 ? 8'($urandom) : MAGIC_ID2);
      member_bytes.push_back(kind == 2 ? 8'($urandom) : METHOD_DEFLATE);
      member_bytes.push_back({reserved, flg});
      repeat (6) member_bytes.push_back(8'($urandom));
      hlen = 10;
      if (flg[FLG_FEXTRA]) begin
         xlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
         member_bytes.push_back(xlen[7:0]);
         member_bytes.push_back(xlen[15:8]);
         for (int i = 0; i < xlen && i < 48; i++) member_bytes.push_back(8'($urandom));
         hlen += 2 + xlen;
      end
      for (int s = 0; s < 2; s++) begin
         if ((s == 0 && flg[FLG_FNAME]) || (s == 1 && flg[FLG_FCOMMENT])) begin
            slen = $urandom_range(0, 4);
            repeat (slen) member_bytes.push_back(8'($urandom_range(1, 255)));
            member_bytes.push_back(8'h00);
            hlen += slen + 1;
         end
      end
      if (flg[FLG_FHCRC]) begin
         repeat (2) member_bytes.push_back(8'($urandom));
         hlen += 2;
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) msize = 31'(hlen + 9 + $urandom_range(0, 2));
      else if (kind < 82) msize = 31'(hlen + 9 - $urandom_range(1, 4));
      else if (kind < 92) msize = 31'($urandom);
      else msize = 31'($urandom_range(0, 17));
      // Either cut the member short, so the next one restarts mid-header,
      // or follow the header with a few deflate bytes.
      if ($urandom_range(0, 99) < 8) begin
         count = $urandom_range(1, member_bytes.size() - 1);
      end else begin
         count = member_bytes.size();
         repeat ($urandom_range(0, 3)) member_bytes.push_back(8'($urandom));
         count = member_bytes.size();
      end
      for (int i = 0; i < count; i++) begin
         send_walked(member_bytes[i], i == 0, i == 0 ? msize : 31'($urandom));
      end
   endtask

   // Receiver: random stalls, one long hold-off on request, and a steady
   // stretch whenever the sender runs without gaps.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= gaps_off || ($urandom_range(0, 99) >= 26);
      end
   end

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      if (fail_count <= PRINT_CAP) begin
         $display("mismatch on response %0d: %s got 0x%0h expected 0x%0h",
                  results_seen, what, got, want);
      end
   endtask

   // Check every accepted response against the oldest expectation.
   always @(posedge clock) begin
      hdr_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("response with nothing pending", {30'd0, rsp_tuser}, 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.phase)
               report_mismatch("phase", {30'd0, rsp_tuser}, {30'd0, want.phase});
            if (rsp_tdata[3:0] !== want.err)
               report_mismatch("error_code", {28'd0, rsp_tdata[3:0]}, {28'd0, want.err});
            if (rsp_tdata[34:4] !== want.offset)
               report_mismatch("data_offset", {1'b0, rsp_tdata[34:4]}, {1'b0, want.offset});
            if (rsp_tdata[39:35] !== want.flags)
               report_mismatch("header_flags", {27'd0, rsp_tdata[39:35]}, {27'd0, want.flags});
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      int unsigned random_sent;
      bit          paused;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      paused = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Edge-case table.
      for (int r = 0; r < EDGE_N; r++) begin
         send_byte(EDGE_ROWS[r].value, EDGE_ROWS[r].size, EDGE_ROWS[r].first,
                   EDGE_ROWS[r].typed, EDGE_ROWS[r].answer);
      end

      // Random members with stray bytes in between.
      random_sent = 0;
      while (random_sent < RANDOM_BYTES) begin
         if (random_sent >= 300) hold_request = 1'b1;
         gaps_off = (random_sent >= 700 && random_sent < 900);
         if (random_sent >= 1100 && !paused) begin
            // Let every response drain before going on.
            paused = 1'b1;
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
         if ($urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 4))
               send_walked(8'($urandom), $urandom_range(0, 3) == 0, 31'($urandom));
         end else begin
            send_member();
         end
         random_sent = bytes_accepted - EDGE_N;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
